### src/dsd_pkg.sv
// Shared constants and types for the decimal short divider.
`timescale 1ns / 1ps

package dsd_pkg;

    // Divisor and remainder width.
    localparam int DIVISOR_BITS = 31;
    // Partial value remainder * 10 + digit stays below 2^(DIVISOR_BITS + 4).
    localparam int P_BITS = DIVISOR_BITS + 4;
    localparam int STEP_BITS = $clog2(P_BITS);
    localparam int DIGIT_BITS = 4;
    localparam int S_TDATA_BITS = 8;
    localparam int M_TDATA_BITS = ((DIGIT_BITS + DIVISOR_BITS + 7) / 8) * 8;
    localparam int M_TUSER_BITS = 2;

    localparam logic [DIGIT_BITS-1:0] DIGIT_MAX = DIGIT_BITS'(9);
    // Quotient bit where the short path starts when the remainder is below the divisor.
    localparam logic [STEP_BITS-1:0] FAST_START = STEP_BITS'(DIGIT_BITS - 1);
    localparam logic [STEP_BITS-1:0] FULL_START = STEP_BITS'(P_BITS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } t_state;

endpackage

### src/decimal_short_division.sv
// Decimal short divider: digit-serial dividend over a restoring shared subtractor.
// Each accepted digit word runs 4 subtract steps in S_RUN, then the result load in S_DONE; 35
//   steps after a divisor write found a nonzero kept remainder; a zero divisor skips them.
// The single subtractor resolves one quotient bit per cycle; a new digit is taken only in idle, once
//   the last result word is loaded; a waiting result word holds the next digit in its load cycle.
// Reset: synchronous active-low; divisor returns to 1, remainder and leading-zero state clear.
`timescale 1ns / 1ps

module decimal_short_division (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Divisor write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dsd_pkg::DIVISOR_BITS-1:0]   i_cfg_data,
    // Digit input: tdata = digit[3:0], zero fill; tlast = final_digit
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dsd_pkg::S_TDATA_BITS-1:0]   i_s_tdata,
    input  logic                               i_s_tlast,
    // Result: tdata = quotient_digit[3:0], remainder, zero fill
    //         tuser = leading_zero, divide_error; tlast = end_of_number
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [dsd_pkg::M_TDATA_BITS-1:0]   o_m_tdata,
    output logic [dsd_pkg::M_TUSER_BITS-1:0]   o_m_tuser,
    output logic                               o_m_tlast
);
    import dsd_pkg::*;

    localparam int FILL_BITS = M_TDATA_BITS - DIGIT_BITS - DIVISOR_BITS;

    t_state                  r_state, n_state;
    logic [DIVISOR_BITS-1:0] r_divisor, n_divisor;
    logic [DIVISOR_BITS-1:0] r_partial, n_partial;
    logic                    r_seen, n_seen;
    logic                    r_in_range, n_in_range;
    logic                    r_m_valid, n_m_valid;

    logic [P_BITS-1:0]       r_p, n_p;
    logic [STEP_BITS-1:0]    r_step, n_step;
    logic [DIVISOR_BITS-1:0] r_acc, n_acc;
    logic [DIGIT_BITS-1:0]   r_q, n_q;
    logic                    r_big, n_big;
    logic                    r_err, n_err;
    logic                    r_last, n_last;

    logic [DIGIT_BITS-1:0]   r_out_q, n_out_q;
    logic [DIVISOR_BITS-1:0] r_out_r, n_out_r;
    logic                    r_out_lz, n_out_lz;
    logic                    r_out_err, n_out_err;
    logic                    r_out_last, n_out_last;

    logic [DIGIT_BITS-1:0]   w_digit;
    logic [P_BITS-1:0]       w_p;
    logic [DIVISOR_BITS:0]   w_shift;
    logic [DIVISOR_BITS+1:0] w_diff;
    logic                    w_ge;
    logic [DIGIT_BITS-1:0]   w_qd;
    logic                    w_seen;
    logic                    w_s_take;
    logic                    w_out_free;

    assign o_cfg_ready = 1'b1;
    assign o_s_tready  = (r_state == S_IDLE);
    assign w_s_take    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_m_valid || i_m_tready;

    // Clamp out-of-range digits to nine.
    assign w_digit = (i_s_tdata[DIGIT_BITS-1:0] > DIGIT_MAX) ? DIGIT_MAX
                                                            : i_s_tdata[DIGIT_BITS-1:0];
    assign w_p = {1'b0, r_partial, 3'b000} + {3'b000, r_partial, 1'b0}
               + {{(P_BITS-DIGIT_BITS){1'b0}}, w_digit};

    // Shared subtractor: one quotient bit per step.
    assign w_shift = {r_acc, r_p[r_step]};
    assign w_diff  = {1'b0, w_shift} - {2'b00, r_divisor};
    assign w_ge    = !w_diff[DIVISOR_BITS+1];

    assign w_qd   = (r_big || r_q > DIGIT_MAX) ? DIGIT_MAX : r_q;
    assign w_seen = r_seen || (w_qd != '0);

    always_comb begin
        n_state    = r_state;
        n_divisor  = r_divisor;
        n_partial  = r_partial;
        n_seen     = r_seen;
        n_in_range = r_in_range;
        n_m_valid  = r_m_valid;
        n_p        = r_p;
        n_step     = r_step;
        n_acc      = r_acc;
        n_q        = r_q;
        n_big      = r_big;
        n_err      = r_err;
        n_last     = r_last;
        n_out_q    = r_out_q;
        n_out_r    = r_out_r;
        n_out_lz   = r_out_lz;
        n_out_err  = r_out_err;
        n_out_last = r_out_last;

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        // A new divisor may sit below the kept remainder: force the full-length path.
        if (i_cfg_valid) begin
            n_divisor  = i_cfg_data;
            n_in_range = (r_partial == '0);
        end

        unique case (r_state)
            S_IDLE: begin
                if (w_s_take) begin
                    n_last = i_s_tlast;
                    n_q    = '0;
                    n_big  = 1'b0;
                    n_p    = w_p;
                    if (r_divisor == '0) begin
                        n_err   = 1'b1;
                        n_acc   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_err   = 1'b0;
                        n_state = S_RUN;
                        if (r_in_range) begin
                            n_step = FAST_START;
                            n_acc  = w_p[P_BITS-1:DIGIT_BITS];
                        end else begin
                            n_step = FULL_START;
                            n_acc  = '0;
                        end
                    end
                end
            end
            S_RUN: begin
                n_acc = w_ge ? w_diff[DIVISOR_BITS-1:0] : w_shift[DIVISOR_BITS-1:0];
                n_q   = {r_q[DIGIT_BITS-2:0], w_ge};
                n_big = r_big || r_q[DIGIT_BITS-1];
                if (r_step == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_step = r_step - STEP_BITS'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_m_valid  = 1'b1;
                    n_out_last = r_last;
                    n_out_err  = r_err;
                    n_in_range = 1'b1;
                    n_state    = S_IDLE;
                    if (r_err) begin
                        n_out_q  = '0;
                        n_out_r  = '0;
                        n_out_lz = 1'b0;
                        n_partial = '0;
                        n_seen    = 1'b0;
                    end else begin
                        n_out_q   = w_qd;
                        n_out_r   = r_acc;
                        n_out_lz  = !w_seen && !r_last;
                        n_partial = r_last ? '0 : r_acc;
                        n_seen    = r_last ? 1'b0 : w_seen;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_divisor  <= DIVISOR_BITS'(1);
            r_partial  <= '0;
            r_seen     <= 1'b0;
            r_in_range <= 1'b1;
            r_m_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_divisor  <= n_divisor;
            r_partial  <= n_partial;
            r_seen     <= n_seen;
            r_in_range <= n_in_range;
            r_m_valid  <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_step     <= n_step;
        r_acc      <= n_acc;
        r_q        <= n_q;
        r_big      <= n_big;
        r_err      <= n_err;
        r_last     <= n_last;
        r_out_q    <= n_out_q;
        r_out_r    <= n_out_r;
        r_out_lz   <= n_out_lz;
        r_out_err  <= n_out_err;
        r_out_last <= n_out_last;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = {{FILL_BITS{1'b0}}, r_out_r, r_out_q};
    assign o_m_tuser  = {r_out_err, r_out_lz};
    assign o_m_tlast  = r_out_last;

    // Running remainder stays below the divisor through every subtract step.
    a_acc_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> ({1'b0, r_acc} < {1'b0, r_divisor}))
        else $error("running remainder not below divisor");

    // Error results carry a zero digit and a zero remainder.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[1]) |-> (o_m_tdata[DIGIT_BITS-1:0] == '0
            && o_m_tdata[DIGIT_BITS+DIVISOR_BITS-1:DIGIT_BITS] == '0 && !o_m_tuser[0]))
        else $error("divide error with nonzero payload");

    // Quotient digit is a decimal digit; the final digit is never a leading zero.
    a_digit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[DIGIT_BITS-1:0] <= DIGIT_MAX && !(o_m_tlast && o_m_tuser[0])))
        else $error("bad quotient digit or leading-zero flag");

    // After a final digit completes, the kept remainder is cleared.
    a_clear_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && w_out_free && r_last) |=> (r_partial == '0 && !r_seen))
        else $error("state not cleared after final digit");

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the decimal short divider: digit streams against a scoreboard.
`timescale 1ns / 1ps

typedef struct {
    logic [dsd_pkg::DIGIT_BITS-1:0]   quot;
    logic                             lead_zero;
    logic [dsd_pkg::DIVISOR_BITS-1:0] rem;
    logic                             last;
    logic                             err;
} t_quot_word;

class quotient_scoreboard;
    logic [dsd_pkg::DIVISOR_BITS-1:0] divisor;
    logic [dsd_pkg::DIVISOR_BITS-1:0] rem_state;
    bit                               seen_nonzero;
    t_quot_word                       expected_q[$];
    int                               fail_count;
    int                               words_checked;
    int                               error_words;

    function new();
        divisor = (dsd_pkg::DIVISOR_BITS)'(1);
        rem_state = '0;
        seen_nonzero = 1'b0;
        fail_count = 0;
        words_checked = 0;
        error_words = 0;
    endfunction

    function void set_divisor(logic [dsd_pkg::DIVISOR_BITS-1:0] value);
        divisor = value;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    // Work out the quotient word for one accepted digit and queue it.
    function void note_digit(logic [dsd_pkg::DIGIT_BITS-1:0] digit, logic last);
        t_quot_word w;
        logic [63:0] part;
        logic [63:0] q;
        logic [63:0] r;
        logic [dsd_pkg::DIGIT_BITS-1:0] d;
        d = (digit > dsd_pkg::DIGIT_MAX) ? dsd_pkg::DIGIT_MAX : digit;
        w.quot = '0;
        w.lead_zero = 1'b0;
        w.rem = '0;
        w.err = 1'b0;
        w.last = last;
        if (divisor == '0) begin
            // abandon the number in progress
            w.err = 1'b1;
            rem_state = '0;
            seen_nonzero = 1'b0;
        end else begin
            part = 64'(rem_state) * 64'd10 + 64'(d);
            q = part / 64'(divisor);
            r = part % 64'(divisor);
            // a remainder left above a smaller divisor can push the digit past nine
            w.quot = (q > 64'd9) ? dsd_pkg::DIGIT_MAX : q[dsd_pkg::DIGIT_BITS-1:0];
            if (w.quot != '0)
                seen_nonzero = 1'b1;
            w.lead_zero = !seen_nonzero && !last;
            w.rem = r[dsd_pkg::DIVISOR_BITS-1:0];
            rem_state = w.rem;
        end
        if (last) begin
            rem_state = '0;
            seen_nonzero = 1'b0;
        end
        expected_q.push_back(w);
    endfunction

    function void compare_field(string field, longint unsigned want, longint unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", field, want, got);
            fail_count++;
        end
    endfunction

    function void check_word(logic [dsd_pkg::M_TDATA_BITS-1:0] tdata,
                             logic [dsd_pkg::M_TUSER_BITS-1:0] tuser, logic tlast);
        t_quot_word w;
        if (expected_q.size() == 0) begin
            $error("result word with no digit outstanding: tdata=%h tuser=%b tlast=%b",
                   tdata, tuser, tlast);
            fail_count++;
            return;
        end
        w = expected_q.pop_front();
        words_checked++;
        if (w.err)
            error_words++;
        compare_field("quotient_digit", w.quot, tdata[dsd_pkg::DIGIT_BITS-1:0]);
        compare_field("remainder", w.rem,
                      tdata[dsd_pkg::DIGIT_BITS +: dsd_pkg::DIVISOR_BITS]);
        compare_field("leading_zero", w.lead_zero, tuser[0]);
        compare_field("divide_error", w.err, tuser[1]);
        compare_field("end_of_number", w.last, tlast);
    endfunction
endclass

module testbench;
    import dsd_pkg::*;

    localparam int SETTLE_CYCLES = 48;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_DIGITS = 84;
    localparam logic [DIVISOR_BITS-1:0] DIV_MAX = '1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_SINK, IDLE_BOTH} t_idle_mode;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic                    o_cfg_ready;
    logic [DIVISOR_BITS-1:0] i_cfg_data = '0;
    logic                    i_s_tvalid = 1'b0;
    logic                    o_s_tready;
    logic [S_TDATA_BITS-1:0] i_s_tdata = '0;
    logic                    i_s_tlast = 1'b0;
    logic                    o_m_tvalid;
    logic                    i_m_tready = 1'b0;
    logic [M_TDATA_BITS-1:0] o_m_tdata;
    logic [M_TUSER_BITS-1:0] o_m_tuser;
    logic                    o_m_tlast;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int digits_sent = 0;
    int cfg_writes = 0;

    quotient_scoreboard sb = new();

    decimal_short_division i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Result side: check each accepted word, then pick the next ready.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_word(o_m_tdata, o_m_tuser, o_m_tlast);
        i_m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    task automatic set_idle(input t_idle_mode mode);
        src_idle_pct = (mode == IDLE_SENDER) ? 83 : (mode == IDLE_BOTH) ? 12 : 0;
        sink_stall_pct = (mode == IDLE_SINK) ? 83 : (mode == IDLE_BOTH) ? 12 : 0;
    endtask

    task automatic send_digit(input logic [DIGIT_BITS-1:0] digit, input logic last);
        int gap;
        gap = 0;
        while ($urandom_range(99) < src_idle_pct && gap < 200)
            gap++;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= S_TDATA_BITS'(digit);
        i_s_tlast <= last;
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_digit(digit, last);
        digits_sent++;
    endtask

    // Hold the digit stream until every expected word is back.
    task automatic drain_results(input int extra);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_divisor(input logic [DIVISOR_BITS-1:0] value);
        drain_results(SETTLE_CYCLES);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        sb.set_divisor(value);
        cfg_writes++;
    endtask

    task automatic send_number(input int len, input bit complete);
        logic [DIGIT_BITS-1:0] digit;
        for (int k = 0; k < len; k++) begin
            case ($urandom_range(9))
                0, 1: digit = '0;
                2: digit = DIGIT_BITS'($urandom_range(15, 10));
                default: digit = DIGIT_BITS'($urandom_range(9));
            endcase
            send_digit(digit, complete && (k == len - 1));
        end
    endtask

    function automatic logic [DIVISOR_BITS-1:0] phase_divisor(input int k);
        case (k % 8)
            0: return DIVISOR_BITS'(1);
            1: return DIV_MAX;
            2: return DIVISOR_BITS'($urandom_range(20, 2));
            3: return '0;
            4: return DIVISOR_BITS'($urandom());
            5: return DIVISOR_BITS'($urandom_range(1000, 2));
            6: return DIVISOR_BITS'(10);
            default: return DIVISOR_BITS'($urandom_range(DIV_MAX, 1 << 20));
        endcase
    endfunction

    initial begin
        int phase_start;
        int len;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_idle(IDLE_NONE);

        // divisor one out of reset: leading zeros and a digit above nine
        send_digit(4'd0, 1'b0);
        send_digit(4'd0, 1'b0);
        send_digit(4'd15, 1'b0);
        send_digit(4'd3, 1'b1);
        write_divisor(DIVISOR_BITS'(7));
        send_digit(4'd0, 1'b0);
        send_digit(4'd12, 1'b0);
        send_digit(4'd5, 1'b0);
        // shrink the divisor mid-number so the kept remainder exceeds it
        write_divisor(DIVISOR_BITS'(3));
        send_digit(4'd9, 1'b0);
        send_digit(4'd1, 1'b1);
        write_divisor(DIV_MAX);
        repeat (9) send_digit(4'd9, 1'b0);
        send_digit(4'd2, 1'b1);
        write_divisor('0);
        send_digit(4'd5, 1'b0);
        send_digit(4'd14, 1'b1);
        send_digit(4'd4, 1'b0);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            write_divisor(phase_divisor(ph));
            set_idle(t_idle_mode'(ph % 4));
            phase_start = digits_sent;
            while (digits_sent - phase_start < PHASE_DIGITS) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(24, 8) : $urandom_range(6, 1);
                // about one number in ten is left open
                send_number(len, $urandom_range(9) != 0);
                if ($urandom_range(19) == 0)
                    drain_results($urandom_range(6, 1));
            end
        end

        drain_results(SETTLE_CYCLES);
        $display("Run covered %0d digit words over %0d divisor writes;", digits_sent, cfg_writes);
        $display("%0d quotient words checked, %0d of them divide-by-zero.",
                 sb.words_checked, sb.error_words);
        if (sb.fail_count == 0)
            $display("decimal_short_division verification clean");
        else
            $display("decimal_short_division verification failed");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("decimal_short_division verification failed");
        $finish;
    end
endmodule

### decimal_short_division.f
src/dsd_pkg.sv
src/decimal_short_division.sv
tb/sv/testbench.sv
